// File: rtl/csle_pkg.sv
// Shared types and constants for the C string literal extractor.
`timescale 1ns / 1ps
package csle_pkg;

  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned MaxBits      = 16;
  localparam int unsigned ResDepth     = 3;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_END      = 3'd1,
    KIND_OK       = 3'd2,
    KIND_UNCLOSED = 3'd3,
    KIND_NONE     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } res_t;

  // results caused by one request, entry 0 goes out first
  typedef struct packed {
    res_t [ResDepth-1:0] res;
    logic [1:0]          cnt;
  } scan_out_t;

endpackage

// File: rtl/csle_scan.sv
// Scanner state and per-byte decode of literals and escapes.
`timescale 1ns / 1ps
module csle_scan #(
  parameter int unsigned COUNT_BITS = csle_pkg::CountBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [7:0]                     byte_i,
  input  logic                           eod_i,
  input  logic [csle_pkg::MaxBits-1:0]   max_strings_i,
  output csle_pkg::scan_out_t            scan_o
);
  import csle_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > MaxBits) ? COUNT_BITS : MaxBits;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChN = 8'h6e;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChV = 8'h76;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChX = 8'h78;
  localparam logic [7:0] Ch0 = 8'h30;
  localparam logic [7:0] Ch7 = 8'h37;

  typedef enum logic [2:0] {
    MODE_OUTSIDE,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_OCTAL,
    MODE_DONE
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [5:0]            pend_q, pend_d;
  logic [1:0]            dc_q, dc_d;
  logic [COUNT_BITS-1:0] seen_q, seen_d;

  res_t [ResDepth-1:0]   res;
  logic [1:0]            n;
  logic                  verdict;
  logic                  str_byte;
  logic [4:0]            hex;
  logic                  is_oct;

  function automatic res_t mk(input kind_e k, input logic [7:0] d);
    res_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    dc_d     = dc_q;
    seen_d   = seen_q;
    res      = '0;
    n        = 2'd0;
    verdict  = 1'b0;
    str_byte = 1'b0;
    hex      = hex_val(byte_i);
    is_oct   = (byte_i >= Ch0) && (byte_i <= Ch7);

    unique case (mode_q)
      MODE_OUTSIDE: begin
        if (byte_i == ChQuote) mode_d = MODE_STRING;
      end
      MODE_STRING: begin
        str_byte = 1'b1;
      end
      MODE_ESCAPE: begin
        mode_d = MODE_STRING;
        unique case (byte_i)
          ChN: begin res[n] = mk(KIND_BYTE, 8'd10); n = n + 2'd1; end
          ChR: begin res[n] = mk(KIND_BYTE, 8'd13); n = n + 2'd1; end
          ChT: begin res[n] = mk(KIND_BYTE, 8'd9);  n = n + 2'd1; end
          ChV: begin res[n] = mk(KIND_BYTE, 8'd11); n = n + 2'd1; end
          ChB: begin res[n] = mk(KIND_BYTE, 8'd8);  n = n + 2'd1; end
          ChF: begin res[n] = mk(KIND_BYTE, 8'd12); n = n + 2'd1; end
          ChX: begin
            mode_d = MODE_HEX;
            pend_d = 6'd0;
            dc_d   = 2'd0;
          end
          default: begin
            if (is_oct) begin
              mode_d = MODE_OCTAL;
              pend_d = {3'd0, byte_i[2:0]};
              dc_d   = 2'd1;
            end else begin
              res[n] = mk(KIND_BYTE, byte_i);
              n = n + 2'd1;
            end
          end
        endcase
      end
      MODE_HEX: begin
        if (hex[4]) begin
          if (dc_q == 2'd1) begin
            res[n] = mk(KIND_BYTE, {pend_q[3:0], hex[3:0]});
            n = n + 2'd1;
            pend_d = 6'd0;
            dc_d   = 2'd0;
            mode_d = MODE_STRING;
          end else begin
            pend_d = {2'd0, hex[3:0]};
            dc_d   = 2'd1;
          end
        end else begin
          res[n] = mk(KIND_BYTE, (dc_q == 2'd0) ? ChX : {2'd0, pend_q});
          n = n + 2'd1;
          pend_d   = 6'd0;
          dc_d     = 2'd0;
          mode_d   = MODE_STRING;
          str_byte = 1'b1;
        end
      end
      MODE_OCTAL: begin
        if (is_oct) begin
          if (dc_q == 2'd2) begin
            res[n] = mk(KIND_BYTE, {pend_q[4:0], byte_i[2:0]});
            n = n + 2'd1;
            pend_d = 6'd0;
            dc_d   = 2'd0;
            mode_d = MODE_STRING;
          end else begin
            pend_d = {pend_q[2:0], byte_i[2:0]};
            dc_d   = dc_q + 2'd1;
          end
        end else begin
          res[n] = mk(KIND_BYTE, {2'd0, pend_q});
          n = n + 2'd1;
          pend_d   = 6'd0;
          dc_d     = 2'd0;
          mode_d   = MODE_STRING;
          str_byte = 1'b1;
        end
      end
      MODE_DONE: begin
        verdict = 1'b1;
      end
      default: begin
        verdict = 1'b1;
      end
    endcase

    if (str_byte) begin
      if (byte_i == ChQuote) begin
        res[n] = mk(KIND_END, 8'd0);
        n = n + 2'd1;
        if (seen_q != '1) seen_d = seen_q + COUNT_BITS'(1);
        if (max_strings_i != '0 && CmpW'(seen_d) >= CmpW'(max_strings_i)) begin
          res[n] = mk(KIND_OK, 8'd0);
          n = n + 2'd1;
          mode_d = MODE_DONE;
        end else begin
          mode_d = MODE_OUTSIDE;
        end
      end else if (byte_i == ChBslash) begin
        mode_d = MODE_ESCAPE;
      end else begin
        res[n] = mk(KIND_BYTE, byte_i);
        n = n + 2'd1;
      end
    end

    if (mode_d == MODE_DONE) verdict = 1'b1;

    if (eod_i) begin
      if (!verdict) begin
        if (mode_d != MODE_OUTSIDE) begin
          res[n] = mk(KIND_UNCLOSED, 8'd0);
        end else if (seen_d == '0) begin
          res[n] = mk(KIND_NONE, 8'd0);
        end else begin
          res[n] = mk(KIND_OK, 8'd0);
        end
        n = n + 2'd1;
      end
      mode_d = MODE_OUTSIDE;
      pend_d = 6'd0;
      dc_d   = 2'd0;
      seen_d = '0;
    end

    if (n != 2'd0) res[n - 2'd1].last = 1'b1;
  end

  assign scan_o.res = res;
  assign scan_o.cnt = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OUTSIDE;
      pend_q <= 6'd0;
      dc_q   <= 2'd0;
      seen_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      dc_q   <= dc_d;
      seen_q <= seen_d;
    end
  end

endmodule

// File: rtl/c_string_literal_extractor.sv
// Top level: byte stream in, decoded C string literal bytes and verdicts out.
`timescale 1ns / 1ps
// Takes one text byte per request on the s_axis side (tlast marks the last byte of the data)
// and emits the decoded bytes of every double-quoted literal, a string-end marker after each,
// and one verdict per data run on the m_axis side (tuser is the kind, tlast marks the last
// result of an input byte). A byte is accepted every cycle while each byte yields at most one
// result and m_axis_tready is high; a byte that yields more (up to 3) holds the single output
// port until all are taken. The input request passes the input register, then the result
// register. cfg_wdata_i sets the string limit (0 = no limit), past which no literal is emitted;
// the user must write it only while idle; the block itself does not enforce this.
module c_string_literal_extractor #(
  parameter int unsigned COUNT_BITS = csle_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csle_pkg::MaxBits-1:0]  cfg_wdata_i,    // max_strings
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // in_byte
  input  logic                          s_axis_tlast,   // end_of_data
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // out_byte
  output logic [2:0]                    m_axis_tuser,   // out_kind
  output logic                          m_axis_tlast    // last_of_run
);
  import csle_pkg::*;

  logic [MaxBits-1:0]   max_q;
  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 in_eod_q;
  res_t [ResDepth-1:0]  res_q;
  logic [1:0]           cnt_q;
  scan_out_t            scan;
  logic                 pop;
  logic                 step;

  assign pop  = m_axis_tvalid && m_axis_tready;
  assign step = in_vld_q && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && pop));
  assign s_axis_tready = !in_vld_q || step;

  csle_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte_q),
    .eod_i         (in_eod_q),
    .max_strings_i (max_q),
    .scan_o        (scan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eod_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (step) begin
      cnt_q <= scan.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // result buffer shifts toward entry 0
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= scan.res;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = res_q[0].data;
  assign m_axis_tuser  = res_q[0].kind;
  assign m_axis_tlast  = res_q[0].last;

`ifndef SYNTHESIS
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (cnt_q == 2'd2 || cnt_q == 2'd3))
    else $error("non-final result without a following entry");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> m_axis_tlast)
    else $error("final buffered result lacks tlast");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_BYTE) |-> (m_axis_tdata == 8'd0))
    else $error("marker result carries nonzero data");

  a_step_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && scan.cnt != 2'd0) |=> (cnt_q == $past(scan.cnt)))
    else $error("result buffer load lost entries");
`endif

endmodule
